>>> rtl/tcls_pkg.sv
// Package for the tuner channel lock search block: item, result, state and
// register types, codes and constants. No dependencies.
package tcls_pkg;

	localparam int FREQ_W    = 16;
	localparam int CNT_W     = 8;
	localparam int FLAGS_W   = 5;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_PROBE  = 2'd1,
		PH_VERIFY = 2'd2
	} phase_t;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_PROBE  = 2'd1;
	localparam logic [1:0] MODE_VERIFY = 2'd2;

	localparam logic [1:0] DET_NONE   = 2'd0;
	localparam logic [1:0] DET_SIGNAL = 2'd1;

	typedef enum logic [2:0] {
		KIND_TUNE      = 3'd0,
		KIND_VERIFY    = 3'd1,
		KIND_FOUND     = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_ABORTED   = 3'd4,
		KIND_IGNORED   = 3'd5
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VHF_LOW_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VHF_HIGH_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_WINDOW    = 3'd4;

	localparam logic [FREQ_W-1:0] RST_MIN_FREQ       = 16'd1392;
	localparam logic [FREQ_W-1:0] RST_MAX_FREQ       = 16'd14000;
	localparam logic [FREQ_W-1:0] RST_VHF_LOW_LIMIT  = 16'd2768;
	localparam logic [FREQ_W-1:0] RST_VHF_HIGH_LIMIT = 16'd7520;
	localparam logic [FREQ_W-1:0] RST_STOP_WINDOW    = 16'd300;

	localparam logic [3:0] AFC_EDGE_UP   = 4'd7;
	localparam logic [3:0] AFC_EDGE_DOWN = 4'd8;

	localparam logic [FLAGS_W-1:0] FLAG_EXTRA  = 5'h01;
	localparam logic [FLAGS_W-1:0] FLAG_EDGE   = 5'h02;
	localparam logic [FLAGS_W-1:0] FLAG_CENTRE = 5'h04;
	localparam logic [FLAGS_W-1:0] FLAG_BELOW  = 5'h0a;
	localparam logic [FLAGS_W-1:0] FLAG_ABOVE  = 5'h10;
	localparam logic [FLAGS_W-1:0] LOCK_FULL   = 5'h1f;
	localparam logic [FLAGS_W-1:0] LOCK_RUN_A  = 5'h1b;
	localparam logic [FLAGS_W-1:0] LOCK_RUN_B  = 5'h1a;

	localparam logic [7:0] LEVEL_MASK = 8'hc0;

	localparam logic [CNT_W-1:0] CNT_MAX     = 8'hff;
	localparam logic [CNT_W-1:0] RUN_MIN     = 8'd4;
	localparam logic [CNT_W-1:0] EDGE_MIN_UP = 8'd3;
	localparam logic [CNT_W-1:0] EDGE_MIN_DN = 8'd0;

	localparam logic [7:0] BAND_VHF_LOW  = 8'he2;
	localparam logic [7:0] BAND_VHF_HIGH = 8'h8e;
	localparam logic [7:0] BAND_UHF      = 8'h44;

	typedef struct packed {
		logic [1:0]        mode;
		logic [FREQ_W-1:0] start_freq;
		logic              search_up;
		logic [7:0]        status_byte;
		logic              stop_key;
		logic [1:0]        detect_code;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [FREQ_W-1:0] tune_freq;
		logic [7:0]        band_byte;
	} result_t;

	typedef struct packed {
		logic [FREQ_W-1:0] min_freq;
		logic [FREQ_W-1:0] max_freq;
		logic [FREQ_W-1:0] vhf_low_limit;
		logic [FREQ_W-1:0] vhf_high_limit;
		logic [FREQ_W-1:0] stop_window;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic               going_up;
		logic [FREQ_W-1:0]  current_freq;
		logic [FREQ_W-1:0]  base_freq;
		logic [FLAGS_W-1:0] lock_flags;
		logic [CNT_W-1:0]   edge_count;
		logic [CNT_W-1:0]   low_level_run;
		logic [FREQ_W-1:0]  candidate_freq;
		logic               cand_valid;
	} state_t;

endpackage

>>> rtl/tuner_channel_lock_search.sv
// Top level of the tuner channel lock search: input register, search state,
// result register and register port. Depends on tcls_pkg and tcls_step.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   mode start_freq search_up status_byte stop_key detect_code
//   out      out_valid / out_stall kind tune_freq band_byte
//   cfg      cfg_valid / cfg_ready cfg_index cfg_data
//
// One item per cycle unless a held result stalls; the step logic works on the item in the input
// register; the result register loads as that item moves on, with out_valid held until taken.
// Reset clears the search to idle and loads the register defaults; cfg_ready is always high.
// A held result stalls the input register, which then stalls the input channel.
module tuner_channel_lock_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           mode,
	input  logic [tcls_pkg::FREQ_W-1:0]          start_freq,
	input  logic                                 search_up,
	input  logic [7:0]                           status_byte,
	input  logic                                 stop_key,
	input  logic [1:0]                           detect_code,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           kind,
	output logic [tcls_pkg::FREQ_W-1:0]          tune_freq,
	output logic [7:0]                           band_byte,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tcls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcls_pkg::FREQ_W-1:0]          cfg_data
);

	tcls_pkg::item_t   item_s1;
	logic              valid_s1;
	tcls_pkg::state_t  state_q;
	tcls_pkg::state_t  state_next;
	tcls_pkg::result_t res_q;
	tcls_pkg::result_t res_next;
	logic              out_valid_q;
	tcls_pkg::cfg_t    cfg_q;
	logic              move_s1;

	assign move_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !move_s1;
	assign cfg_ready = 1'b1;

	tcls_step u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.nxt  (state_next),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || move_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.mode        <= mode;
			item_s1.start_freq  <= start_freq;
			item_s1.search_up   <= search_up;
			item_s1.status_byte <= status_byte;
			item_s1.stop_key    <= stop_key;
			item_s1.detect_code <= detect_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{phase: tcls_pkg::PH_IDLE, default: '0};
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			state_q     <= state_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_freq       <= tcls_pkg::RST_MIN_FREQ;
			cfg_q.max_freq       <= tcls_pkg::RST_MAX_FREQ;
			cfg_q.vhf_low_limit  <= tcls_pkg::RST_VHF_LOW_LIMIT;
			cfg_q.vhf_high_limit <= tcls_pkg::RST_VHF_HIGH_LIMIT;
			cfg_q.stop_window    <= tcls_pkg::RST_STOP_WINDOW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tcls_pkg::CFG_MIN_FREQ:       cfg_q.min_freq       <= cfg_data;
				tcls_pkg::CFG_MAX_FREQ:       cfg_q.max_freq       <= cfg_data;
				tcls_pkg::CFG_VHF_LOW_LIMIT:  cfg_q.vhf_low_limit  <= cfg_data;
				tcls_pkg::CFG_VHF_HIGH_LIMIT: cfg_q.vhf_high_limit <= cfg_data;
				tcls_pkg::CFG_STOP_WINDOW:    cfg_q.stop_window    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign tune_freq = res_q.tune_freq;
	assign band_byte = res_q.band_byte;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.kind == tcls_pkg::KIND_NOT_FOUND ||
			res_q.kind == tcls_pkg::KIND_ABORTED ||
			res_q.kind == tcls_pkg::KIND_IGNORED))
		|-> (res_q.tune_freq == '0 && res_q.band_byte == '0))
		else $error("terminal result carries a frequency");

	a_verify_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && res_next.kind == tcls_pkg::KIND_VERIFY)
		|=> (state_q.phase == tcls_pkg::PH_VERIFY))
		else $error("verify tune without verifying phase");

	a_found_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && (res_next.kind == tcls_pkg::KIND_FOUND ||
			res_next.kind == tcls_pkg::KIND_NOT_FOUND ||
			res_next.kind == tcls_pkg::KIND_ABORTED))
		|=> (state_q.phase == tcls_pkg::PH_IDLE))
		else $error("search end without idle phase");

endmodule

>>> rtl/tcls_step.sv
// Single-item step of the channel search: next search state and result from
// the registered item, current state and registers. Depends on tcls_pkg.
module tcls_step (
	input  tcls_pkg::item_t   item,
	input  tcls_pkg::state_t  st,
	input  tcls_pkg::cfg_t    cfg,
	output tcls_pkg::state_t  nxt,
	output tcls_pkg::result_t res
);

	logic [3:0]                  afc;
	logic                        past;
	logic                        extra;
	logic                        do_adv;
	logic                        at_end;
	tcls_pkg::kind_t             kind;
	logic [tcls_pkg::FREQ_W-1:0] freq;

	assign afc   = item.status_byte[4:1];
	assign extra = st.going_up ? (afc == tcls_pkg::AFC_EDGE_UP) : (afc == tcls_pkg::AFC_EDGE_DOWN);
	assign past  = st.going_up
		? ({1'b0, st.current_freq} > ({1'b0, st.base_freq} + {1'b0, cfg.stop_window}))
		: (({1'b0, st.current_freq} + {1'b0, cfg.stop_window}) < {1'b0, st.base_freq});

	always_comb begin
		nxt    = st;
		kind   = tcls_pkg::KIND_IGNORED;
		freq   = '0;
		do_adv = 1'b0;
		at_end = 1'b0;
		case (item.mode)
			tcls_pkg::MODE_START: begin
				nxt.current_freq   = item.start_freq;
				nxt.base_freq      = item.start_freq;
				nxt.going_up       = item.search_up;
				nxt.lock_flags     = '0;
				nxt.edge_count     = '0;
				nxt.low_level_run  = '0;
				nxt.candidate_freq = '0;
				nxt.cand_valid     = 1'b0;
				nxt.phase          = tcls_pkg::PH_PROBE;
				kind               = tcls_pkg::KIND_TUNE;
				freq               = item.start_freq;
			end
			tcls_pkg::MODE_PROBE: begin
				if (st.phase == tcls_pkg::PH_PROBE) begin
					if (past && item.stop_key) begin
						nxt.phase = tcls_pkg::PH_IDLE;
						kind      = tcls_pkg::KIND_ABORTED;
					end else begin
						case (afc) inside
							tcls_pkg::AFC_EDGE_UP, tcls_pkg::AFC_EDGE_DOWN: begin
								if (extra) begin
									nxt.lock_flags = tcls_pkg::FLAG_EXTRA;
									if (st.going_up) begin
										if (st.current_freq != '1)
											nxt.current_freq = st.current_freq + 16'd1;
									end else begin
										if (st.current_freq != '0)
											nxt.current_freq = st.current_freq - 16'd1;
									end
								end else begin
									if (st.edge_count != tcls_pkg::CNT_MAX)
										nxt.edge_count = st.edge_count + 8'd1;
									nxt.lock_flags = st.lock_flags | tcls_pkg::FLAG_EDGE;
								end
							end
							[4'd1:4'd6]: nxt.lock_flags = st.lock_flags | tcls_pkg::FLAG_BELOW;
							[4'd9:4'd14]: nxt.lock_flags = st.lock_flags | tcls_pkg::FLAG_ABOVE;
							default: begin
								nxt.lock_flags     = st.lock_flags | tcls_pkg::FLAG_CENTRE;
								nxt.candidate_freq = st.current_freq;
								nxt.cand_valid     = 1'b1;
							end
						endcase
						if (nxt.lock_flags == tcls_pkg::LOCK_RUN_A ||
								nxt.lock_flags == tcls_pkg::LOCK_RUN_B) begin
							if (st.low_level_run != tcls_pkg::CNT_MAX)
								nxt.low_level_run = st.low_level_run + 8'd1;
							if (!nxt.cand_valid) begin
								nxt.candidate_freq = nxt.current_freq;
								nxt.cand_valid     = 1'b1;
							end
						end else begin
							nxt.low_level_run = '0;
						end
						if ((item.status_byte & tcls_pkg::LEVEL_MASK) != tcls_pkg::LEVEL_MASK) begin
							nxt.lock_flags = '0;
							nxt.edge_count = '0;
							do_adv         = 1'b1;
						end else if ((nxt.lock_flags == tcls_pkg::LOCK_FULL ||
								nxt.low_level_run > tcls_pkg::RUN_MIN) &&
								(st.going_up ? (nxt.edge_count > tcls_pkg::EDGE_MIN_UP)
									: (nxt.edge_count > tcls_pkg::EDGE_MIN_DN))) begin
							nxt.phase = tcls_pkg::PH_VERIFY;
							kind      = tcls_pkg::KIND_VERIFY;
							freq      = nxt.candidate_freq;
						end else begin
							do_adv = 1'b1;
						end
					end
				end
			end
			tcls_pkg::MODE_VERIFY: begin
				if (st.phase == tcls_pkg::PH_VERIFY) begin
					if (item.detect_code == tcls_pkg::DET_SIGNAL) begin
						nxt.phase = tcls_pkg::PH_IDLE;
						kind      = tcls_pkg::KIND_FOUND;
						freq      = st.candidate_freq;
					end else begin
						if (item.detect_code == tcls_pkg::DET_NONE) begin
							nxt.low_level_run = '0;
							nxt.lock_flags    = '0;
							nxt.edge_count    = '0;
						end
						nxt.candidate_freq = '0;
						nxt.cand_valid     = 1'b0;
						nxt.phase          = tcls_pkg::PH_PROBE;
						do_adv             = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (do_adv) begin
			at_end = st.going_up ? (nxt.current_freq >= cfg.max_freq)
				: (nxt.current_freq <= cfg.min_freq);
			if (at_end) begin
				nxt.phase = tcls_pkg::PH_IDLE;
				kind      = tcls_pkg::KIND_NOT_FOUND;
				freq      = '0;
			end else begin
				nxt.current_freq = st.going_up ? (nxt.current_freq + 16'd1)
					: (nxt.current_freq - 16'd1);
				kind = tcls_pkg::KIND_TUNE;
				freq = nxt.current_freq;
			end
		end
	end

	always_comb begin
		res.kind      = kind;
		res.tune_freq = freq;
		res.band_byte = '0;
		if (kind == tcls_pkg::KIND_TUNE || kind == tcls_pkg::KIND_VERIFY ||
				kind == tcls_pkg::KIND_FOUND) begin
			if (freq < cfg.vhf_low_limit)
				res.band_byte = tcls_pkg::BAND_VHF_LOW;
			else if (freq < cfg.vhf_high_limit)
				res.band_byte = tcls_pkg::BAND_VHF_HIGH;
			else
				res.band_byte = tcls_pkg::BAND_UHF;
		end
	end

endmodule
